@@ rtl/core/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper package
// Character codes, sequence sizes and the escape helper functions.
// ----------------------------------------------------------------------------
package jse_pkg;

  typedef logic [7:0] byte_t;

  localparam int BODY_LEN = 6;            // longest escape: backslash u 0 0 X X
  localparam int SEQ_LEN  = BODY_LEN + 2; // plus opening and closing quote

  typedef logic [2:0] body_cnt_t;          // 1, 2 or 6
  typedef logic [3:0] seq_cnt_t;           // 1 .. SEQ_LEN

  localparam byte_t CH_QUOTE   = 8'h22;
  localparam byte_t CH_BSLASH  = 8'h5C;
  localparam byte_t CH_U       = 8'h75;
  localparam byte_t CH_ZERO    = 8'h30;
  localparam byte_t CTRL_LIMIT = 8'h20;

  localparam byte_t CH_BS  = 8'h08;
  localparam byte_t CH_HT  = 8'h09;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_FF  = 8'h0C;
  localparam byte_t CH_CR  = 8'h0D;

  localparam byte_t LET_B  = 8'h62;
  localparam byte_t LET_F  = 8'h66;
  localparam byte_t LET_N  = 8'h6E;
  localparam byte_t LET_R  = 8'h72;
  localparam byte_t LET_T  = 8'h74;
  localparam byte_t NO_LETTER = 8'h00;

  localparam body_cnt_t BODY_PLAIN = 3'd1;
  localparam body_cnt_t BODY_SHORT = 3'd2;
  localparam body_cnt_t BODY_LONG  = 3'd6;

  // Letter after the backslash for a two-byte escape, NO_LETTER otherwise.
  function automatic byte_t esc_letter(input byte_t c);
    byte_t l;
    case (c)
      CH_BS:     l = LET_B;
      CH_FF:     l = LET_F;
      CH_LF:     l = LET_N;
      CH_CR:     l = LET_R;
      CH_HT:     l = LET_T;
      CH_QUOTE:  l = CH_QUOTE;
      CH_BSLASH: l = CH_BSLASH;
      default:   l = NO_LETTER;
    endcase
    return l;
  endfunction

  // Lower-case hex digit.
  function automatic byte_t hex_digit(input logic [3:0] n);
    byte_t d;
    if (n < 4'd10) begin
      d = CH_ZERO + {4'd0, n};
    end else begin
      d = 8'h57 + {4'd0, n};
    end
    return d;
  endfunction

endpackage

@@ rtl/core/json_string_escaper_top.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper
// Words pass the input, body, sequence and serializer stages and the output
// register. Throughput: one output word per cycle while out_stall is low; an
// input word is taken every cycle while each yields one; a longer one holds
// the serializer until sent. Reset clears all stage valid bits at once.
// ----------------------------------------------------------------------------
module json_string_escaper_top
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_first_of_string,
  input  logic       in_last_of_string,
  input  logic       in_empty_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  // Stage 1: input register
  logic      s1_v_r;
  byte_t     s1_char_r;
  logic      s1_first_r, s1_last_r, s1_empty_r;

  // Stage 2: escape body
  logic      s2_v_r;
  byte_t     s2_body_r [BODY_LEN];
  body_cnt_t s2_blen_r;
  logic      s2_first_r, s2_last_r, s2_empty_r;
  byte_t     s2_body_nxt [BODY_LEN];
  body_cnt_t s2_blen_nxt;

  // Stage 3: full sequence with quotes
  logic      s3_v_r;
  byte_t     s3_seq_r [SEQ_LEN];
  seq_cnt_t  s3_cnt_r;
  byte_t     s3_seq_nxt [SEQ_LEN];
  seq_cnt_t  s3_cnt_nxt;

  // Stage 4: serializer
  logic      s4_v_r;
  byte_t     s4_seq_r [SEQ_LEN];
  seq_cnt_t  s4_rem_r;

  // Output register
  logic      out_valid_r;
  byte_t     out_byte_r;
  logic      out_last_r;

  logic out_ld, s4_emit, s4_done, s4_ld, s3_ld, s2_ld, s1_ld;
  byte_t letter;

  assign out_ld  = !out_valid_r || !out_stall;
  assign s4_emit = s4_v_r && out_ld;
  assign s4_done = s4_emit && (s4_rem_r == seq_cnt_t'(1));
  assign s4_ld   = !s4_v_r || s4_done;
  assign s3_ld   = !s3_v_r || s4_ld;
  assign s2_ld   = !s2_v_r || s3_ld;
  assign s1_ld   = !s1_v_r || s2_ld;
  assign in_stall = !s1_ld;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  // Escape body from the raw byte
  assign letter = esc_letter(s1_char_r);

  always_comb begin
    for (int i = 0; i < BODY_LEN; i++) begin
      s2_body_nxt[i] = '0;
    end
    if (letter != NO_LETTER) begin
      s2_body_nxt[0] = CH_BSLASH;
      s2_body_nxt[1] = letter;
      s2_blen_nxt    = BODY_SHORT;
    end else if (s1_char_r < CTRL_LIMIT) begin
      s2_body_nxt[0] = CH_BSLASH;
      s2_body_nxt[1] = CH_U;
      s2_body_nxt[2] = CH_ZERO;
      s2_body_nxt[3] = CH_ZERO;
      s2_body_nxt[4] = hex_digit(s1_char_r[7:4]);
      s2_body_nxt[5] = hex_digit(s1_char_r[3:0]);
      s2_blen_nxt    = BODY_LONG;
    end else begin
      s2_body_nxt[0] = s1_char_r;
      s2_blen_nxt    = BODY_PLAIN;
    end
  end

  // Wrap the body in optional quotes
  always_comb begin
    seq_cnt_t base;
    seq_cnt_t close_at;
    base     = {3'd0, s2_first_r};
    close_at = base + {1'b0, s2_blen_r};
    for (int i = 0; i < SEQ_LEN; i++) begin
      s3_seq_nxt[i] = '0;
    end
    if (s2_empty_r) begin
      s3_seq_nxt[0] = CH_QUOTE;
      s3_seq_nxt[1] = CH_QUOTE;
      s3_cnt_nxt    = seq_cnt_t'(2);
    end else begin
      for (int i = 0; i < SEQ_LEN; i++) begin
        if (s2_first_r) begin
          if (i == 0) begin
            s3_seq_nxt[i] = CH_QUOTE;
          end else if (i - 1 < BODY_LEN) begin
            s3_seq_nxt[i] = s2_body_r[i-1];
          end
        end else if (i < BODY_LEN) begin
          s3_seq_nxt[i] = s2_body_r[i];
        end
        if (s2_last_r && (seq_cnt_t'(i) == close_at)) begin
          s3_seq_nxt[i] = CH_QUOTE;
        end
      end
      s3_cnt_nxt = close_at + {3'd0, s2_last_r};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ld) s1_v_r <= in_valid;
      if (s2_ld) s2_v_r <= s1_v_r;
      if (s3_ld) s3_v_r <= s2_v_r;
      if (s4_ld) s4_v_r <= s3_v_r;
      if (out_ld) out_valid_r <= s4_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_char_r  <= in_char_byte;
      s1_first_r <= in_first_of_string;
      s1_last_r  <= in_last_of_string;
      s1_empty_r <= in_empty_string;
    end
    if (s2_ld) begin
      s2_body_r  <= s2_body_nxt;
      s2_blen_r  <= s2_blen_nxt;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_empty_r <= s1_empty_r;
    end
    if (s3_ld) begin
      s3_seq_r <= s3_seq_nxt;
      s3_cnt_r <= s3_cnt_nxt;
    end
    // load a new word when the last one is gone, else shift out one byte
    if (s4_ld) begin
      s4_seq_r <= s3_seq_r;
      s4_rem_r <= s3_cnt_r;
    end else if (s4_emit) begin
      for (int i = 0; i < SEQ_LEN - 1; i++) begin
        s4_seq_r[i] <= s4_seq_r[i+1];
      end
      s4_seq_r[SEQ_LEN-1] <= '0;
      s4_rem_r <= s4_rem_r - seq_cnt_t'(1);
    end
    if (out_ld) begin
      out_byte_r <= s4_seq_r[0];
      out_last_r <= (s4_rem_r == seq_cnt_t'(1));
    end
  end

endmodule

@@ tb/json_string_escaper_top_tb.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper testbench
// Feeds directed and random string bytes through the escaper, predicts the
// escaped text of every accepted word and compares it byte by byte, with
// random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module json_string_escaper_top_tb
  import jse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam byte_t CH_LOWER_A = 8'h61;
  localparam int    RANDOM_WORDS = 250;

  typedef struct packed {
    byte_t text;
    logic  last;
  } text_byte_t;

  // Holds the escaped text still owed by the block and checks each result.
  class escaped_text_board;
    text_byte_t pending_text[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function byte_t hex_char(logic [3:0] n);
      if (n < 4'd10) begin
        return CH_ZERO + byte_t'(n);
      end
      return CH_LOWER_A + byte_t'(n) - 8'd10;
    endfunction

    // Letter after the backslash for the short escapes, NO_LETTER otherwise.
    function byte_t short_letter(byte_t c);
      case (c)
        CH_BS:     return LET_B;
        CH_FF:     return LET_F;
        CH_LF:     return LET_N;
        CH_CR:     return LET_R;
        CH_HT:     return LET_T;
        CH_QUOTE:  return CH_QUOTE;
        CH_BSLASH: return CH_BSLASH;
        default:   return NO_LETTER;
      endcase
    endfunction

    function void note_word(byte_t c, logic first, logic last, logic empty);
      byte_t run[$];
      byte_t letter;
      if (empty) begin
        run.push_back(CH_QUOTE);
        run.push_back(CH_QUOTE);
      end else begin
        if (first) run.push_back(CH_QUOTE);
        letter = short_letter(c);
        if (letter != NO_LETTER) begin
          run.push_back(CH_BSLASH);
          run.push_back(letter);
        end else if (c < CTRL_LIMIT) begin
          run.push_back(CH_BSLASH);
          run.push_back(CH_U);
          run.push_back(CH_ZERO);
          run.push_back(CH_ZERO);
          run.push_back(hex_char(c[7:4]));
          run.push_back(hex_char(c[3:0]));
        end else begin
          run.push_back(c);
        end
        if (last) run.push_back(CH_QUOTE);
      end
      foreach (run[i]) pending_text.push_back('{run[i], i == run.size() - 1});
    endfunction

    task check_word(byte_t text, logic last);
      text_byte_t want;
      if (pending_text.size() == 0) begin
        report_mismatch($sformatf("byte 0x%02h arrived with nothing pending", text));
        return;
      end
      want = pending_text.pop_front();
      if (text !== want.text)
        report_mismatch($sformatf("out_byte 0x%02h, predicted 0x%02h", text, want.text));
      if (last !== want.last)
        report_mismatch($sformatf("out_last_of_run %b, predicted %b on byte 0x%02h",
                                  last, want.last, want.text));
    endtask

    function int pending();
      return pending_text.size();
    endfunction

    task check_drained();
      if (pending_text.size() != 0)
        report_mismatch($sformatf("%0d bytes never arrived", pending_text.size()));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_byte;
  logic       in_first_of_string;
  logic       in_last_of_string;
  logic       in_empty_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  escaped_text_board text_sb;
  bit steady;          // no gaps and no stalls while set
  bit burst;           // sender offers back to back
  int hold_off_cycles; // receiver stall request, counted down by the receiver
  int words_sent;

  json_string_escaper_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_byte       (in_char_byte),
    .in_first_of_string (in_first_of_string),
    .in_last_of_string  (in_last_of_string),
    .in_empty_string    (in_empty_string),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last_of_run    (out_last_of_run)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic byte_t pick_char();
    byte_t specials[7] = '{CH_BS, CH_FF, CH_LF, CH_CR, CH_HT, CH_QUOTE, CH_BSLASH};
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return byte_t'($urandom_range(8'h20, 8'h7E));
    if (r < 55) return byte_t'($urandom_range(0, 8'h1F));
    if (r < 70) return specials[$urandom_range(0, 6)];
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input byte_t c, input logic first, input logic last,
                           input logic empty);
    int gap;
    gap = (steady || burst) ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_char_byte       <= c;
    in_first_of_string <= first;
    in_last_of_string  <= last;
    in_empty_string    <= empty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    text_sb.note_word(c, first, last, empty);
    words_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_string(input int len);
    if (len == 0) begin
      send_word(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b1);
    end else begin
      for (int i = 0; i < len; i++) send_word(pick_char(), i == 0, i == len - 1, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (text_sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: random stall runs, quiet while steady, long hold when asked.
  initial begin
    int  run_left;
    bit  run_stalled;
    run_left    = 0;
    run_stalled = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stalled = ($urandom_range(0, 2) == 0);
          run_left    = run_stalled ? pick_gap() + 1 : $urandom_range(1, 12);
        end
        out_stall <= run_stalled;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) text_sb.check_word(out_byte, out_last_of_run);
  end

  initial begin
    int random_start;
    text_sb            = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_char_byte       = 8'h00;
    in_first_of_string = 1'b0;
    in_last_of_string  = 1'b0;
    in_empty_string    = 1'b0;
    steady             = 1'b0;
    burst              = 1'b0;
    hold_off_cycles    = 0;
    words_sent         = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty strings ignore the byte and both marks.
    send_word(8'hA5, 1'b1, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b1, 1'b1);
    // Zero byte with both quotes: the longest run.
    send_word(8'h00, 1'b1, 1'b1, 1'b0);
    send_word(CH_BS, 1'b1, 1'b0, 1'b0);
    send_word(CH_FF, 1'b0, 1'b0, 1'b0);
    send_word(CH_LF, 1'b0, 1'b0, 1'b0);
    send_word(CH_CR, 1'b0, 1'b0, 1'b0);
    send_word(CH_HT, 1'b0, 1'b0, 1'b0);
    send_word(CH_QUOTE, 1'b0, 1'b0, 1'b0);
    send_word(CH_BSLASH, 1'b0, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b1, 1'b0);
    send_word(8'h0B, 1'b1, 1'b0, 1'b0);
    send_word(8'h10, 1'b0, 1'b0, 1'b0);
    send_word(8'h1F, 1'b0, 1'b0, 1'b0);
    send_word(8'h20, 1'b0, 1'b0, 1'b0);
    send_word(8'h7F, 1'b0, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1, 1'b0);
    // Unbalanced marks: last without first, first repeated.
    send_word(8'h41, 1'b0, 1'b1, 1'b0);
    send_word(8'h42, 1'b1, 1'b0, 1'b0);
    send_word(8'h43, 1'b1, 1'b0, 1'b0);

    // Hold the output while the sender keeps offering, so the block backs up.
    hold_off_cycles = 120;
    burst = 1'b1;
    repeat (5) send_string($urandom_range(4, 8));
    burst = 1'b0;
    drop_valid();
    wait_drained();

    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_word(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_string($urandom_range(0, 8));
      end
    end
    steady = 1'b0;
    drop_valid();

    wait_drained();
    repeat (10) @(posedge clk);
    text_sb.check_drained();
    if (text_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
